// ===== rtl/css_pkg.sv =====
// Shared constants, types and helpers for the cosine-squared switching unit.
`timescale 1ns / 1ps
`default_nettype none
package css_pkg;

  // Field widths and fixed-point formats.
  localparam int WORD_W       = 32;
  localparam int FRAC_BITS    = 16;
  localparam int RECIP_W      = 48;
  localparam int ANGLE_W      = 34;
  localparam int CORDIC_STEPS = 24;
  localparam int DIV_STEPS    = 31;

  // Pipeline layout: capture, divider, angle scale, rotations, five tail stages.
  localparam int PIPE_DEPTH  = DIV_STEPS + CORDIC_STEPS + 7;
  localparam int SLOPE_SHIFT = 61 - 2 * FRAC_BITS;

  localparam logic [30:0] ONE_Q30     = 31'd1073741824;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic signed [ANGLE_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [RECIP_W-1:0] RECIP_RESET = 48'd2147483648;
  localparam logic signed [WORD_W-1:0] WINDOW_LOW_RESET  = 32'sd0;
  localparam logic signed [WORD_W-1:0] WINDOW_HIGH_RESET = 32'sd65536;

  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  // Arctangent of 2^-i in Q2.30, truncated.
  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
    32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
    32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255,
    32'd127, 32'd63, 32'd31, 32'd15, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
  };

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_WINDOW_LOW  = 1'b0,
    REG_WINDOW_HIGH = 1'b1
  } cfg_reg_t;

  // Values that ride along with every point in the pipeline.
  typedef struct packed {
    logic signed [WORD_W-1:0] u;
    logic signed [WORD_W-1:0] f;
    logic                     inwin;
    logic                     err;
  } pt_ctl_t;

  // Window state derived from the configuration registers.
  typedef struct packed {
    logic                     busy;
    logic signed [WORD_W-1:0] lo;
    logic [WORD_W-1:0]        span;
    logic [RECIP_W-1:0]       recip;
  } win_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [WORD_W-1:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/css_if.sv =====
// Request channels of the switching unit: points in, results out, register writes.
`timescale 1ns / 1ps
`default_nettype none

// Point channel.
interface css_in_if;
  logic                     valid;
  logic                     ready;
  logic signed [31:0]       position;
  logic signed [31:0]       potential;
  logic signed [31:0]       force_req;
  modport source (output valid, position, potential, force_req, input ready);
  modport sink   (input valid, position, potential, force_req, output ready);
endinterface

// Result channel.
interface css_out_if;
  logic                     valid;
  logic                     ready;
  logic signed [31:0]       potential_out;
  logic signed [31:0]       force_out;
  logic [30:0]              switch_weight;
  logic [30:0]              switch_slope;
  logic                     in_window;
  logic                     span_error;
  modport source (output valid, potential_out, force_out, switch_weight, switch_slope,
                  in_window, span_error, input ready);
  modport sink   (input valid, potential_out, force_out, switch_weight, switch_slope,
                  in_window, span_error, output ready);
endinterface

// Register write channel.
interface css_cfg_if;
  logic                     valid;
  logic                     ready;
  css_pkg::cfg_reg_t        index;
  logic [31:0]              data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/css_recip.sv =====
// Window bound ordering and bit-serial reciprocal of the window span.
`timescale 1ns / 1ps
`default_nettype none
module css_recip (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic signed [css_pkg::WORD_W-1:0] raw_lo,
  input  wire logic signed [css_pkg::WORD_W-1:0] raw_hi,
  output css_pkg::win_t                        win
);

  localparam int CNT_W = $clog2(css_pkg::RECIP_W);

  logic                              pending;
  logic                              busy;
  logic signed [css_pkg::WORD_W-1:0] lo;
  logic [css_pkg::WORD_W-1:0]        span;
  logic [css_pkg::RECIP_W-1:0]       recip;
  logic [css_pkg::RECIP_W-1:0]       quot;
  logic [css_pkg::WORD_W-1:0]        rem;
  logic [CNT_W-1:0]                  cnt;

  logic signed [css_pkg::WORD_W-1:0] ord_lo;
  logic signed [css_pkg::WORD_W-1:0] ord_hi;
  logic [css_pkg::WORD_W:0]          ord_span;
  logic [css_pkg::WORD_W:0]          rem_sh;
  logic [css_pkg::WORD_W:0]          rem_diff;
  logic                              ge;

  // Put the bounds in order and take their distance.
  always_comb begin
    if (raw_lo > raw_hi) begin
      ord_lo = raw_hi;
      ord_hi = raw_lo;
    end else begin
      ord_lo = raw_lo;
      ord_hi = raw_hi;
    end
    ord_span = {ord_hi[css_pkg::WORD_W-1], ord_hi} - {ord_lo[css_pkg::WORD_W-1], ord_lo};
  end

  // One quotient bit of 2^47 / span per cycle; the dividend has a single one at the top.
  always_comb begin
    rem_sh   = {rem, (cnt == CNT_W'(css_pkg::RECIP_W - 1))};
    ge       = rem_sh >= {1'b0, span};
    rem_diff = rem_sh - (ge ? {1'b0, span} : '0);
  end

  // Sequencer: a write arms it, the armed state loads the bounds, then 48 steps follow.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      busy    <= 1'b0;
      lo      <= css_pkg::WINDOW_LOW_RESET;
      span    <= 32'(css_pkg::WINDOW_HIGH_RESET - css_pkg::WINDOW_LOW_RESET);
      recip   <= css_pkg::RECIP_RESET;
      cnt     <= '0;
    end else if (start) begin
      pending <= 1'b1;
      busy    <= 1'b0;
    end else if (pending) begin
      pending <= 1'b0;
      lo      <= ord_lo;
      span    <= ord_span[css_pkg::WORD_W-1:0];
      cnt     <= CNT_W'(css_pkg::RECIP_W - 1);
      if (ord_span[css_pkg::WORD_W-1:0] == '0) begin
        recip <= '0;
        busy  <= 1'b0;
      end else begin
        busy  <= 1'b1;
      end
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        recip <= {quot[css_pkg::RECIP_W-2:0], ge};
        busy  <= 1'b0;
      end
    end
  end

  // Divider datapath.
  always_ff @(posedge clk) begin
    if (pending) begin
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      rem  <= rem_diff[css_pkg::WORD_W-1:0];
      quot <= {quot[css_pkg::RECIP_W-2:0], ge};
    end
  end

  assign win.busy  = busy | pending;
  assign win.lo    = lo;
  assign win.span  = span;
  assign win.recip = recip;

  // A write always leaves the sequencer armed on the next cycle.
  a_start_arms: assert property (@(posedge clk) disable iff (rst) start |=> pending)
    else $error("register write did not arm the reciprocal sequencer");
  // The step counter only runs down while the divider is working.
  a_cnt_moves: assert property (@(posedge clk) disable iff (rst)
    (!busy && !pending && !start) |=> $stable(cnt))
    else $error("reciprocal counter moved while idle");
  // A zero span never leaves the divider running.
  a_zero_idle: assert property (@(posedge clk) disable iff (rst)
    (busy && !start) |-> span != '0)
    else $error("divider running on a zero span");

endmodule
`default_nettype wire

// ===== rtl/cosine_squared_switch_unit.sv =====
// Top level of the cosine-squared switching unit: point pipeline and register port.
//
// Usage: points (position, potential, force_req; signed Q16.16) arrive on the
// point channel and one result per point leaves on the result channel, in order.
// Registers window_low (index 0) and window_high (index 1) are written on the
// cfg channel while no point is in flight; each write starts a bit-serial
// reciprocal of the window span (no division when the span is zero), during
// which point.ready stays low. Reset loads the window [0, 1.0] with its
// reciprocal ready, so points are taken in the first cycle after reset.
// Pipeline: after its point is accepted, a result passes through one capture
// stage, 31 divider stages (one quotient bit each), one angle scaling stage,
// 24 CORDIC rotation stages, five multiply stages and the output register.
// Throughput: one point per cycle while no reciprocal runs. When the receiver
// stalls, the result waits in the output register and the pipeline moves on
// until its last stage holds a point; then it holds, losing or repeating none.
`timescale 1ns / 1ps
`default_nettype none
module cosine_squared_switch_unit (
  input wire logic  clk,
  input wire logic  rst,
  css_cfg_if.sink   cfg,
  css_in_if.sink    point,
  css_out_if.source result
);

  localparam int W   = css_pkg::WORD_W;
  localparam int AW  = css_pkg::ANGLE_W;
  localparam int NC  = css_pkg::CORDIC_STEPS;
  localparam int ND  = css_pkg::DIV_STEPS;
  localparam int NP  = css_pkg::PIPE_DEPTH;

  // Register port.
  logic signed [W-1:0] raw_lo;
  logic signed [W-1:0] raw_hi;
  logic                cfg_write;
  css_pkg::win_t       win;

  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid & cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_lo <= css_pkg::WINDOW_LOW_RESET;
      raw_hi <= css_pkg::WINDOW_HIGH_RESET;
    end else if (cfg_write) begin
      unique case (cfg.index)
        css_pkg::REG_WINDOW_LOW:  raw_lo <= cfg.data;
        css_pkg::REG_WINDOW_HIGH: raw_hi <= cfg.data;
        default: ;
      endcase
    end
  end

  css_recip u_recip (
    .clk    (clk),
    .rst    (rst),
    .start  (cfg_write),
    .raw_lo (raw_lo),
    .raw_hi (raw_hi),
    .win    (win)
  );

  // Flow control: the pipeline moves unless its last stage would overrun a held result.
  logic [NP-1:0]    v;
  logic             en;
  logic             pt_take;
  logic             ov;

  assign en          = !v[NP-1] || !ov || result.ready;
  assign point.ready = en && !win.busy;
  assign pt_take     = point.valid && point.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NP-2:0], pt_take};
    end
  end

  // Side data that travels with every point.
  css_pkg::pt_ctl_t ctl [NP];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 1; i < NP; i++) begin
        ctl[i] <= ctl[i-1];
      end
    end
  end

  // Capture stage: offset from the lower bound and window test.
  logic [W:0]   rem [ND+1];
  logic [ND-1:0] quo [ND+1];
  logic [W:0]   offset;
  logic         span_zero;
  logic         in_range;

  always_comb begin
    offset    = {point.position[W-1], point.position} - {win.lo[W-1], win.lo};
    span_zero = (win.span == '0);
    in_range  = !offset[W] && (offset[W-1:0] <= win.span);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl[0].u     <= point.potential;
      ctl[0].f     <= point.force_req;
      ctl[0].err   <= span_zero;
      ctl[0].inwin <= !span_zero && in_range;
      rem[0]       <= offset;
      quo[0]       <= '0;
    end
  end

  // Restoring divider, one quotient bit per stage: t = offset * 2^30 / span.
  for (genvar k = 0; k < ND; k++) begin : g_div
    logic       ge;
    logic [W:0] diff;
    always_comb begin
      ge   = rem[k] >= {1'b0, win.span};
      diff = rem[k] - (ge ? {1'b0, win.span} : '0);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= {diff[W-1:0], 1'b0};
        quo[k+1] <= {quo[k][ND-2:0], ge};
      end
    end
  end

  // Angle scaling theta = t * pi/2, then the CORDIC start vector.
  logic signed [AW-1:0] cx [NC+1];
  logic signed [AW-1:0] cy [NC+1];
  logic signed [AW-1:0] cz [NC+1];
  logic [61:0]          theta_prod;

  assign theta_prod = quo[ND] * css_pkg::HALF_PI_Q30;

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0] <= css_pkg::CORDIC_GAIN;
      cy[0] <= '0;
      cz[0] <= $signed({2'b00, theta_prod[61:30]});
    end
  end

  // Rotation stages.
  for (genvar i = 0; i < NC; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (en) begin
        if (cz[i] >= 0) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - $signed({2'b00, css_pkg::ATAN_Q30[i]});
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + $signed({2'b00, css_pkg::ATAN_Q30[i]});
        end
      end
    end
  end

  // Weight stage: clamp cos and sin, w = c*c, sin(2 theta) = 2*c*s.
  localparam logic signed [AW-1:0] ONE_WIDE = $signed({3'b000, css_pkg::ONE_Q30});
  logic [30:0] cos_c;
  logic [30:0] sin_c;
  logic [61:0] cc_prod;
  logic [61:0] cs_prod;
  logic [30:0] w_w;
  logic [30:0] w_sin2;

  always_comb begin
    if (cx[NC] < 0) begin
      cos_c = '0;
    end else if (cx[NC] > ONE_WIDE) begin
      cos_c = css_pkg::ONE_Q30;
    end else begin
      cos_c = cx[NC][30:0];
    end
    if (cy[NC] < 0) begin
      sin_c = '0;
    end else if (cy[NC] > ONE_WIDE) begin
      sin_c = css_pkg::ONE_Q30;
    end else begin
      sin_c = cy[NC][30:0];
    end
    cc_prod = cos_c * cos_c;
    cs_prod = cos_c * sin_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_w <= cc_prod[60:30];
      if (cs_prod[61:29] > {2'b00, css_pkg::ONE_Q30}) begin
        w_sin2 <= css_pkg::ONE_Q30;
      end else begin
        w_sin2 <= cs_prod[59:29];
      end
    end
  end

  // Stage A: a = sin(2 theta) * pi/2.
  logic [61:0] a_prod;
  logic [30:0] a_a;
  logic [30:0] a_w;

  assign a_prod = w_sin2 * css_pkg::HALF_PI_Q30;

  always_ff @(posedge clk) begin
    if (en) begin
      a_a <= a_prod[60:30];
      a_w <= w_w;
    end
  end

  // Stage B: partial products of a times the 48-bit span reciprocal.
  logic [62:0] b_hi;
  logic [46:0] b_lo;
  logic [30:0] b_w;

  always_ff @(posedge clk) begin
    if (en) begin
      b_hi <= a_a * win.recip[css_pkg::RECIP_W-1:16];
      b_lo <= a_a * win.recip[15:0];
      b_w  <= a_w;
    end
  end

  // Stage C: slope with saturation, and w*u.
  logic [63:0]        slope_sum;
  logic [63:0]        slope_tot;
  logic [30:0]        c_s;
  logic [30:0]        c_w;
  logic signed [63:0] c_wu;

  always_comb begin
    slope_sum = {1'b0, b_hi} + {33'b0, b_lo[46:16]};
    slope_tot = slope_sum >> css_pkg::SLOPE_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_s  <= (slope_tot > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : slope_tot[30:0];
      c_w  <= b_w;
      c_wu <= $signed({1'b0, b_w}) * ctl[ND+NC+4].u;
    end
  end

  // Stage D: s*u and w*f.
  logic [30:0]        d_s;
  logic [30:0]        d_w;
  logic signed [63:0] d_wu;
  logic signed [63:0] d_su;
  logic signed [63:0] d_wf;

  always_ff @(posedge clk) begin
    if (en) begin
      d_s  <= c_s;
      d_w  <= c_w;
      d_wu <= c_wu;
      d_su <= $signed({1'b0, c_s}) * ctl[ND+NC+5].u;
      d_wf <= $signed({1'b0, c_w}) * ctl[ND+NC+5].f;
    end
  end

  // Final sums, saturation and pass-through selection.
  css_pkg::pt_ctl_t   last;
  logic signed [63:0] f_sum;
  logic signed [W-1:0] u_fin;
  logic signed [W-1:0] f_fin;

  always_comb begin
    last  = ctl[NP-1];
    f_sum = (d_su >>> css_pkg::FRAC_BITS) + (d_wf >>> 30);
    u_fin = css_pkg::sat32(d_wu >>> 30);
    f_fin = css_pkg::sat32(f_sum);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (!ov || result.ready) begin
      ov <= v[NP-1] && en;
    end
  end

  always_ff @(posedge clk) begin
    if (!ov || result.ready) begin
      result.in_window  <= last.inwin;
      result.span_error <= last.err;
      if (last.inwin) begin
        result.potential_out <= u_fin;
        result.force_out     <= f_fin;
        result.switch_weight <= d_w;
        result.switch_slope  <= d_s;
      end else begin
        result.potential_out <= last.u;
        result.force_out     <= last.f;
        result.switch_weight <= css_pkg::ONE_Q30;
        result.switch_slope  <= '0;
      end
    end
  end

  assign result.valid = ov;

  // The pipeline only holds when a finished point waits behind a stalled result.
  a_hold_reason: assert property (@(posedge clk) disable iff (rst)
    !en |-> (v[NP-1] && ov && !result.ready))
    else $error("pipeline held without a blocked result");
  // No point enters while a register write has the reciprocal sequencer armed.
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> !pt_take)
    else $error("point accepted right after a register write");
  // A switched point never carries the zero-span flag.
  a_flags: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.in_window && result.span_error))
    else $error("in_window and span_error both set");
  // The weight never exceeds 1.0.
  a_weight: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.switch_weight <= css_pkg::ONE_Q30)
    else $error("switch weight above one");

endmodule
`default_nettype wire

// ===== dv/cosine_squared_switch_unit_tb.sv =====
// Self-checking testbench for the cosine-squared switching unit.
`timescale 1ns / 1ps
`default_nettype none
module cosine_squared_switch_unit_tb;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int SETTLE_WAIT  = 70;
  localparam int RANDOM_ITEMS = 520;

  typedef struct {
    logic signed [31:0] pot;
    logic signed [31:0] frc;
    logic [30:0]        weight;
    logic [30:0]        slope;
    logic               inwin;
    logic               err;
  } switched_point_t;

  logic clk;
  logic rst;
  css_cfg_if cfg ();
  css_in_if  point ();
  css_out_if result ();

  cosine_squared_switch_unit dut (
    .clk(clk), .rst(rst), .cfg(cfg.sink), .point(point.sink), .result(result.source)
  );

  // Window copy kept alongside the block.
  longint          win_low;
  longint          win_high;
  longint unsigned win_recip;

  switched_point_t pending_points[$];
  int              error_count = 0;
  int              cycle_count = 0;
  int              send_idle_pct;
  int              recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Rebuild the span reciprocal from the current bounds.
  function automatic void refresh_window();
    longint lo, hi;
    longint unsigned span;
    lo = win_low;
    hi = win_high;
    if (lo > hi) begin
      lo = win_high;
      hi = win_low;
    end
    span = longint'(hi - lo);
    win_recip = (span != 0) ? ((64'd1 << 47) / span) : 64'd0;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Compute the switched point for one point request.
  function automatic switched_point_t switch_point(input logic signed [31:0] pos,
                                                   input logic signed [31:0] pot,
                                                   input logic signed [31:0] frc);
    switched_point_t sp;
    longint lo, hi, x, u, f, tq, z, cx, cy, dx, dy, w, sin2, amp, s;
    longint unsigned span, d, hip, lop, tot;
    x = pos;
    u = pot;
    f = frc;
    lo = win_low;
    hi = win_high;
    if (lo > hi) begin
      lo = win_high;
      hi = win_low;
    end
    span = longint'(hi - lo);
    sp.pot = pot;
    sp.frc = frc;
    sp.weight = css_pkg::ONE_Q30;
    sp.slope = '0;
    sp.inwin = 1'b0;
    sp.err = 1'b0;
    if (span == 0) begin
      sp.err = 1'b1;
    end else if (x >= lo && x <= hi) begin
      d = longint'(x - lo);
      tq = longint'((d << 30) / span);
      z = (tq * longint'(css_pkg::HALF_PI_Q30)) >>> 30;
      cx = longint'(css_pkg::CORDIC_GAIN);
      cy = 0;
      for (int i = 0; i < css_pkg::CORDIC_STEPS && i < 32; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (z >= 0) begin
          cx -= dx; cy += dy; z -= longint'(css_pkg::ATAN_Q30[i]);
        end else begin
          cx += dx; cy -= dy; z += longint'(css_pkg::ATAN_Q30[i]);
        end
      end
      if (cx < 0) cx = 0;
      if (cx > longint'(css_pkg::ONE_Q30)) cx = longint'(css_pkg::ONE_Q30);
      if (cy < 0) cy = 0;
      if (cy > longint'(css_pkg::ONE_Q30)) cy = longint'(css_pkg::ONE_Q30);
      w = (cx * cx) >>> 30;
      sin2 = (cx * cy) >>> 29;
      if (sin2 > longint'(css_pkg::ONE_Q30)) sin2 = longint'(css_pkg::ONE_Q30);
      amp = (sin2 * longint'(css_pkg::HALF_PI_Q30)) >>> 30;
      hip = longint'(amp) * (win_recip >> 16);
      lop = longint'(amp) * (win_recip & 64'hFFFF);
      tot = (hip + (lop >> 16)) >> css_pkg::SLOPE_SHIFT;
      s = (tot > 64'd2147483647) ? 64'sd2147483647 : longint'(tot);
      sp.pot = 32'(clamp32((w * u) >>> 30));
      sp.frc = 32'(clamp32(((s * u) >>> css_pkg::FRAC_BITS) + ((w * f) >>> 30)));
      sp.weight = w[30:0];
      sp.slope = s[30:0];
      sp.inwin = 1'b1;
    end
    return sp;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Result checker and receiver stalls.
  always @(posedge clk) begin
    switched_point_t want;
    cycle_count <= cycle_count + 1;
    result.ready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && result.valid && result.ready) begin
      if (pending_points.size() == 0) begin
        report_mismatch("unexpected result, queue depth", 1, 0);
      end else begin
        want = pending_points.pop_front();
        if (result.potential_out !== want.pot)
          report_mismatch("potential_out", result.potential_out, want.pot);
        if (result.force_out !== want.frc)
          report_mismatch("force_out", result.force_out, want.frc);
        if (result.switch_weight !== want.weight)
          report_mismatch("switch_weight", result.switch_weight, want.weight);
        if (result.switch_slope !== want.slope)
          report_mismatch("switch_slope", result.switch_slope, want.slope);
        if (result.in_window !== want.inwin)
          report_mismatch("in_window", result.in_window, want.inwin);
        if (result.span_error !== want.err)
          report_mismatch("span_error", result.span_error, want.err);
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Send one point request, with random idle cycles ahead of it.
  task automatic send_point(input logic [31:0] pos, input logic [31:0] pot,
                            input logic [31:0] frc);
    while ($urandom_range(99) < send_idle_pct) begin
      point.valid <= 1'b0;
      @(posedge clk);
    end
    point.valid <= 1'b1;
    point.position <= pos;
    point.potential <= pot;
    point.force_req <= frc;
    do @(posedge clk); while (!point.ready);
    pending_points.push_back(switch_point(pos, pot, frc));
  endtask

  // Let the pipeline drain, then write one window register.
  task automatic write_window(input css_pkg::cfg_reg_t idx, input logic [31:0] value);
    point.valid <= 1'b0;
    @(posedge clk);
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == css_pkg::REG_WINDOW_LOW) win_low = longint'(signed'(value));
    else win_high = longint'(signed'(value));
    refresh_window();
  endtask

  task automatic set_window(input logic [31:0] lo, input logic [31:0] hi);
    write_window(css_pkg::REG_WINDOW_LOW, lo);
    write_window(css_pkg::REG_WINDOW_HIGH, hi);
  endtask

  // Position drawn mostly inside the current window.
  function automatic logic [31:0] pick_position();
    longint lo, hi;
    longint unsigned span;
    lo = win_low;
    hi = win_high;
    if (lo > hi) begin
      lo = win_high;
      hi = win_low;
    end
    span = longint'(hi - lo);
    if ($urandom_range(99) < 15 || span == 0) return $urandom();
    if ($urandom_range(9) == 0) return ($urandom_range(1)) ? lo[31:0] : hi[31:0];
    return lo[31:0] + 32'({$urandom(), $urandom()} % (span + 1));
  endfunction

  // Directed points on the reset window [0, 1.0].
  task automatic test_reset_window();
    send_point(32'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'd65536, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'd32768, 32'h0001_0000, 32'hFFFF_0000);
    send_point(32'd16384, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'd49152, 32'h8000_0000, 32'h8000_0000);
    send_point(32'd1, 32'hFFFF_FFFF, 32'd0);
    send_point(32'd65535, 32'h5555_5555, 32'hAAAA_AAAA);
    send_point(32'hFFFF_FFFF, 32'h1234_5678, 32'h8765_4321);
    send_point(32'd65537, 32'hAAAA_AAAA, 32'h5555_5555);
    send_point(32'h7FFF_FFFF, 32'd7, 32'd9);
    send_point(32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // Bounds written in reverse order are swapped by the block.
  task automatic test_swapped_bounds();
    set_window(32'h0004_0000, 32'hFFFF_0000);
    send_point(32'hFFFF_0000, 32'h0100_0000, 32'h0200_0000);
    send_point(32'h0004_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h0001_8000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h0004_0001, 32'h1111_1111, 32'h2222_2222);
  endtask

  // Equal bounds flag a span error, also at the bound itself.
  task automatic test_zero_span();
    set_window(32'h0002_0000, 32'h0002_0000);
    send_point(32'h0002_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h0001_0000, 32'h0000_1000, 32'hFFFF_F000);
  endtask

  // Full-range window and a one-LSB window.
  task automatic test_extreme_windows();
    set_window(32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_point(32'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    set_window(32'd100, 32'd101);
    send_point(32'd100, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'd101, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'd102, 32'h7FFF_FFFF, 32'h8000_0000);
  endtask

  // Random windows and points under one idling mix.
  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
    logic [31:0] a, b;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        a = $urandom();
        case ($urandom_range(3))
          0: b = a + $urandom_range(1, 200);
          1: b = a - $urandom_range(1, 1 << 20);
          2: b = $urandom();
          default: b = a + $urandom_range(1 << 10, 1 << 24);
        endcase
        if ($urandom_range(19) == 0) b = a;
        set_window(a, b);
      end
      send_point(pick_position(), $urandom(), $urandom());
    end
  endtask

  initial begin
    rst = 1'b1;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    point.valid = 1'b0;
    point.position = '0;
    point.potential = '0;
    point.force_req = '0;
    cfg.valid = 1'b0;
    cfg.index = css_pkg::REG_WINDOW_LOW;
    cfg.data = '0;
    win_low = 0;
    win_high = 65536;
    refresh_window();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_reset_window();
    test_swapped_bounds();
    test_zero_span();
    test_extreme_windows();
    test_random_phase(0, 0, RANDOM_ITEMS / 4);
    test_random_phase(68, 0, RANDOM_ITEMS / 4);
    test_random_phase(0, 68, RANDOM_ITEMS / 4);
    test_random_phase(38, 38, RANDOM_ITEMS / 4);

    point.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== cosine_squared_switch_unit.f =====
rtl/css_pkg.sv
rtl/css_if.sv
rtl/css_recip.sv
rtl/cosine_squared_switch_unit.sv
dv/cosine_squared_switch_unit_tb.sv
